// ----- rtl/kam_pkg.sv -----
`timescale 1ns / 1ps

package kam_pkg;

    // table geometry
    localparam int ENTRIES   = 128;
    localparam int NAME_BITS = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    // fixed field widths
    localparam int CMD_W  = 3;
    localparam int KEY_W  = 64;
    localparam int DATA_W = 32;

    // stream packing
    localparam int S_TDATA_W = 2 * KEY_W + DATA_W;
    localparam int M_TDATA_W = 2 * DATA_W;
    localparam int M_TUSER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        OP_SET = 3'd0,
        OP_SHW = 3'd1,
        OP_ADD = 3'd2,
        OP_LDR = 3'd3,
        OP_INC = 3'd4,
        OP_DEC = 3'd5,
        OP_STR = 3'd6
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] fill_count;
        logic             out_free;
    } t_dp_status;

endpackage

// ----- rtl/keyed_accumulator_machine.sv -----
`timescale 1ns / 1ps

// keyed accumulator machine: runs one instruction per input beat (set, show,
// add, load, increment, decrement, store) against a table of up to 128 named
// 32-bit variables and one 32-bit accumulator, and returns one result beat per
// instruction. names are matched on their low 64 bits; absent names read as 0
// and a write to an absent name takes the next free slot, or is dropped and
// flagged when the table is full. each instruction passes through the accept
// cycle, one scan over the filled slots through the single read port of the
// name table plus a final compare, where both names of an add are matched in
// the same pass, then the update. the update waits while a previous result is
// still held on the output, but the next beat is accepted as soon as the
// update is done. no clearing pass after reset: the fill count marks the live
// slots
module keyed_accumulator_machine
    import kam_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // key_a, key_b, set operand
    input  logic [CMD_W-1:0]     i_s_tuser,   // cmd
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // read_value, acc_value
    output logic [M_TUSER_W-1:0] o_m_tuser    // key_found, insert_dropped
);

    // command and status between sequencer and datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: accept, scan the filled slots, commit
    kam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // tables, accumulator, fill count and the output result register
    kam_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ----- rtl/kam_ctrl.sv -----
`timescale 1ns / 1ps

module kam_ctrl
    import kam_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             scan_more;

    assign scan_more = (r_idx < i_status.fill_count);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_s_tready   = 1'b0;
        o_cmd        = '0;
        o_cmd.rd_addr = r_idx[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                // no beat is taken while reset is held
                o_s_tready = i_rst_n;
                if (i_rst_n && i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // last compare lands on the same edge that leaves this state
                if (scan_more) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + CNT_W'(1);
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_idx < i_status.fill_count))
        else $error("table read beyond filled slots");

    a_load_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("accepted beat did not start a scan");

    a_commit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_status.out_free)
        else $error("commit while result register busy");

endmodule

// ----- rtl/kam_datapath.sv -----
`timescale 1ns / 1ps

module kam_datapath
    import kam_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [CMD_W-1:0]     i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [M_TUSER_W-1:0] o_m_tuser
);

    // name and value tables, one read port and one write port each
    logic [NAME_BITS-1:0] r_names [ENTRIES];
    logic [DATA_W-1:0]    r_values[ENTRIES];

    // latched instruction
    logic [CMD_W-1:0]     r_cmd;
    logic [NAME_BITS-1:0] r_key_a, r_key_b;
    logic [DATA_W-1:0]    r_setv;

    // scan pipeline
    logic                 r_rd_valid;
    logic [IDX_W-1:0]     r_rd_addr;
    logic [NAME_BITS-1:0] r_rd_name;
    logic [DATA_W-1:0]    r_rd_val;

    // search results
    logic                 r_found_a, r_found_b;
    logic [IDX_W-1:0]     r_slot_a;
    logic [DATA_W-1:0]    r_val_a, r_val_b;

    // architectural state
    logic [CNT_W-1:0]     r_fill;
    logic [DATA_W-1:0]    r_acc;

    // result register
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_read, r_out_acc;
    logic                 r_out_found, r_out_dropped;

    logic [DATA_W-1:0]    va, vb, n_wr_val, n_acc;
    logic                 is_write, table_full, do_update, do_insert, n_dropped;

    assign table_full = (r_fill == CNT_W'(ENTRIES));
    assign va = r_found_a ? r_val_a : '0;
    assign vb = r_found_b ? r_val_b : '0;

    always_comb begin
        is_write = 1'b0;
        n_wr_val = r_setv;
        n_acc    = r_acc;
        case (t_op'(r_cmd))
            OP_SET: begin
                is_write = 1'b1;
            end
            OP_ADD: begin
                n_acc = r_acc + va + vb;
            end
            OP_LDR: begin
                n_acc = va;
            end
            OP_INC: begin
                is_write = 1'b1;
                n_wr_val = va + DATA_W'(1);
            end
            OP_DEC: begin
                is_write = 1'b1;
                n_wr_val = va - DATA_W'(1);
            end
            OP_STR: begin
                is_write = 1'b1;
                n_wr_val = r_acc;
                n_acc    = '0;
            end
            default: begin
            end
        endcase
    end

    assign do_update = i_cmd.commit && is_write && r_found_a;
    assign do_insert = i_cmd.commit && is_write && !r_found_a && !table_full;
    assign n_dropped = is_write && !r_found_a && table_full;

    // table write and scan read
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            r_names[r_fill[IDX_W-1:0]]  <= r_key_a;
            r_values[r_fill[IDX_W-1:0]] <= n_wr_val;
        end else if (do_update) begin
            r_values[r_slot_a] <= n_wr_val;
        end
        if (i_cmd.rd_en) begin
            r_rd_name <= r_names[i_cmd.rd_addr];
            r_rd_val  <= r_values[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_s_tuser;
            r_key_a <= i_s_tdata[NAME_BITS-1:0];
            r_key_b <= i_s_tdata[KEY_W +: NAME_BITS];
            r_setv  <= i_s_tdata[2*KEY_W +: DATA_W];
        end
        r_rd_addr <= i_cmd.rd_addr;
        if (i_cmd.load) begin
            r_found_a <= 1'b0;
            r_found_b <= 1'b0;
        end else if (r_rd_valid) begin
            // names are unique in the table, so at most one hit per key
            if (r_rd_name == r_key_a) begin
                r_found_a <= 1'b1;
                r_slot_a  <= r_rd_addr;
                r_val_a   <= r_rd_val;
            end
            if (r_rd_name == r_key_b) begin
                r_found_b <= 1'b1;
                r_val_b   <= r_rd_val;
            end
        end
        if (i_cmd.commit) begin
            r_out_read    <= va;
            r_out_found   <= r_found_a;
            r_out_acc     <= n_acc;
            r_out_dropped <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_fill      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_en;
            if (i_cmd.commit) begin
                r_acc <= n_acc;
            end
            if (do_insert) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.fill_count = r_fill;
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_acc, r_out_read};
    assign o_m_tuser  = {r_out_dropped, r_out_found};

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(ENTRIES))
        else $error("fill count beyond table size");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dropped) |-> table_full)
        else $error("insert dropped with free slots");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed result not presented");

endmodule
